>>> sv/acm_pkg.sv
package acm_pkg;

    // Word and field widths fixed by the instruction format
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 7;
    localparam int ACT_W         = 4;
    localparam int ERR_W         = 2;
    localparam int MEM_WORDS_DEF = 100;

    // Divider step counter
    localparam int CNT_W = $clog2(DATA_W);

    // Instruction codes; codes 12 to 15 are no-ops
    typedef enum logic [ACT_W-1:0] {
        ACT_READ   = 4'd0,
        ACT_WRITE  = 4'd1,
        ACT_LOAD   = 4'd2,
        ACT_STORE  = 4'd3,
        ACT_ADD    = 4'd4,
        ACT_SUB    = 4'd5,
        ACT_DIV    = 4'd6,
        ACT_MUL    = 4'd7,
        ACT_BR     = 4'd8,
        ACT_BRNEG  = 4'd9,
        ACT_BRZERO = 4'd10,
        ACT_PAUSE  = 4'd11
    } t_action;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DIV_OVF  = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_state;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } t_div_rsp;

    // One result transaction
    typedef struct packed {
        logic [DATA_W-1:0] accumulator_value;
        logic [DATA_W-1:0] write_data;
        logic              write_valid;
        logic [ADDR_W-1:0] next_pc;
        logic              branch_taken;
        logic              paused;
        logic [ERR_W-1:0]  error_code;
    } t_result;

endpackage

>>> sv/acm_in_if.sv
interface acm_in_if
    import acm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic [ADDR_W-1:0]        address;
    logic signed [DATA_W-1:0] read_value;

    modport source (output valid, action, address, read_value, input ready);
    modport sink   (input valid, action, address, read_value, output ready);
endinterface

>>> sv/acm_out_if.sv
interface acm_out_if
    import acm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] accumulator_value;
    logic signed [DATA_W-1:0] write_data;
    logic                     write_valid;
    logic [ADDR_W-1:0]        next_pc;
    logic                     branch_taken;
    logic                     paused;
    logic [ERR_W-1:0]         error_code;

    modport source (output valid, accumulator_value, write_data, write_valid, next_pc,
                    branch_taken, paused, error_code, input ready);
    modport sink   (input valid, accumulator_value, write_data, write_valid, next_pc,
                    branch_taken, paused, error_code, output ready);
endinterface

>>> sv/acm_ram.sv
module acm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 100
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/acm_divider.sv
module acm_divider
    import acm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;

    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;
    logic [DATA_W-1:0] w_abs_dvd;
    logic [DATA_W-1:0] w_abs_dvs;

    // Magnitudes of the operands; the most negative word maps to 2^31 unsigned
    assign w_abs_dvd = i_req.dividend[DATA_W-1] ? (~i_req.dividend + 1'b1) : i_req.dividend;
    assign w_abs_dvs = i_req.divisor[DATA_W-1]  ? (~i_req.divisor + 1'b1)  : i_req.divisor;

    // One restoring step: shift in the next dividend bit, trial subtract
    assign w_shift = {r_rem, r_quo[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= w_abs_dvd;
            r_den <= w_abs_dvs;
            r_neg <= i_req.dividend[DATA_W-1] ^ i_req.divisor[DATA_W-1];
        end else if (r_busy) begin
            if (!w_diff[DATA_W]) begin
                r_rem <= w_diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
        end
    end

    // Sign fix gives truncation toward zero
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (~r_quo + 1'b1) : r_quo;
endmodule

>>> sv/accumulator_machine_execute_top.sv
// Channel  Direction  Transaction
// i_in     sink       action, address, read_value
// o_out    source     accumulator_value, write_data, write_valid, next_pc,
//                     branch_taken, paused, error_code
//
// One instruction at a time, taken through accept, execute and hand-off; a divide
// adds a wait on the one-bit-per-cycle divider before the hand-off.
// The data memory is a one-port-read RAM read at accept; write-back happens in
// the execute cycle, before the next instruction can read.
// Reset clears accumulator, counter and one valid flop per memory word at once.
// The next instruction is accepted while a result still waits in the output
// register; a stalled output holds the block in its hand-off state.
module accumulator_machine_execute_top
    import acm_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    acm_in_if.sink    i_in,
    acm_out_if.source o_out
);
    localparam int AW = $clog2(MEM_WORDS);

    t_state r_state, n_state;

    // Captured instruction
    logic [ACT_W-1:0]  r_action;
    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_rval;
    logic              r_in_rng;
    logic              r_opnd_vld;

    // Architectural state
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [ADDR_W-1:0] r_pc, n_pc;
    logic [MEM_WORDS-1:0] r_valid;

    // Results
    t_result r_pend, n_pend;
    t_result r_out;
    logic    r_out_valid;

    logic              w_accept;
    logic              w_in_rng;
    logic [AW-1:0]     w_in_idx;
    logic [AW-1:0]     w_ex_idx;
    logic [DATA_W-1:0] w_rdata;
    logic [DATA_W-1:0] w_operand;
    logic              w_we;
    logic [DATA_W-1:0] w_wdata;
    logic              w_out_free;
    logic [ADDR_W-1:0] w_pc_inc;
    logic [ADDR_W-1:0] w_mod_tab [2**ADDR_W];
    logic              w_taken;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    // Branch target reduced modulo the memory size
    for (genvar g = 0; g < 2**ADDR_W; g++) begin : g_mod
        assign w_mod_tab[g] = ADDR_W'(g % MEM_WORDS);
    end

    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_rng   = (i_in.address < ADDR_W'(MEM_WORDS));
    assign w_in_idx   = w_in_rng ? i_in.address[AW-1:0] : '0;
    assign w_ex_idx   = r_addr[AW-1:0];
    assign w_operand  = (r_in_rng && r_opnd_vld) ? w_rdata : '0;
    assign w_pc_inc   = (r_pc == ADDR_W'(MEM_WORDS - 1)) ? '0 : (r_pc + 1'b1);
    assign w_out_free = !r_out_valid || o_out.ready;

    acm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_ex_idx),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_in_idx),
        .o_rdata (w_rdata)
    );

    acm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Capture instruction and operand valid flag at accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action   <= i_in.action;
            r_addr     <= i_in.address;
            r_rval     <= $unsigned(i_in.read_value);
            r_in_rng   <= w_in_rng;
            r_opnd_vld <= r_valid[w_in_idx];
        end
    end

    // State register and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_pc    <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_pc    <= n_pc;
            if (w_we) begin
                r_valid[w_ex_idx] <= 1'b1;
            end
        end
    end

    // Execute sequencer
    always_comb begin
        n_state            = r_state;
        n_acc              = r_acc;
        n_pc               = r_pc;
        n_pend             = r_pend;
        w_we               = 1'b0;
        w_wdata            = r_acc;
        w_taken            = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_acc;
        w_div_req.divisor  = w_operand;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state            = S_DONE;
                n_pend.write_data  = '0;
                n_pend.write_valid = 1'b0;
                n_pend.paused      = 1'b0;
                n_pend.error_code  = ERR_NONE;
                unique case (r_action)
                    ACT_READ: begin
                        w_we    = r_in_rng;
                        w_wdata = r_rval;
                    end
                    ACT_WRITE: begin
                        n_pend.write_data  = w_operand;
                        n_pend.write_valid = r_in_rng;
                    end
                    ACT_LOAD:  n_acc = w_operand;
                    ACT_STORE: w_we  = r_in_rng;
                    ACT_ADD:   n_acc = r_acc + w_operand;
                    ACT_SUB:   n_acc = r_acc - w_operand;
                    ACT_DIV: begin
                        priority if (w_operand == '0) begin
                            n_pend.error_code = ERR_DIV_ZERO;
                        end else if (r_acc == {1'b1, {(DATA_W-1){1'b0}}} &&
                                     w_operand == '1) begin
                            n_pend.error_code = ERR_DIV_OVF;
                        end else begin
                            w_div_req.start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end
                    ACT_MUL:    n_acc   = r_acc * w_operand;
                    ACT_BR:     w_taken = 1'b1;
                    ACT_BRNEG:  w_taken = r_acc[DATA_W-1];
                    ACT_BRZERO: w_taken = (r_acc == '0);
                    ACT_PAUSE:  n_pend.paused = 1'b1;
                    default: ;
                endcase
                n_pc                     = w_taken ? w_mod_tab[r_addr] : w_pc_inc;
                n_pend.next_pc           = n_pc;
                n_pend.branch_taken      = w_taken;
                n_pend.accumulator_value = n_acc;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_acc                    = w_div_rsp.quotient;
                    n_pend.accumulator_value = w_div_rsp.quotient;
                    n_state                  = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Pending result
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out <= r_pend;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.accumulator_value = $signed(r_out.accumulator_value);
    assign o_out.write_data        = $signed(r_out.write_data);
    assign o_out.write_valid       = r_out.write_valid;
    assign o_out.next_pc           = r_out.next_pc;
    assign o_out.branch_taken      = r_out.branch_taken;
    assign o_out.paused            = r_out.paused;
    assign o_out.error_code        = r_out.error_code;

    // An accepted instruction always executes in the following cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted instruction did not execute");

    // Divider finishes only while the sequencer waits on it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider result outside divide wait");

    // Program counter stays inside the memory
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc < ADDR_W'(MEM_WORDS))
        else $error("program counter out of range");

    // A memory write never coincides with an operand read
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> !w_accept)
        else $error("memory write overlaps operand read");

endmodule
